@@ sv/dpbmb_pkg.sv @@
// ----------------------------------------------------------------------------
// dpbmb_pkg - shared types and constants for the dark pixel block binner
// Limits, register indexes and the structs passed between the stages.
// ----------------------------------------------------------------------------
package dpbmb_pkg;

  // Region limits
  localparam int MAX_CELLS_ACROSS = 128;
  localparam int MAX_CELL_SIZE    = 30;
  localparam int MAX_CELLS_DOWN   = 128;

  // Field widths
  localparam int COL_W    = (MAX_CELLS_ACROSS > 1) ? $clog2(MAX_CELLS_ACROSS) : 1;
  localparam int ACR_W    = (COL_W >= 8) ? COL_W + 1 : 9;
  localparam int SIZE_W   = 5;
  localparam int ROW_W    = 7;
  localparam int OUT_CW   = 7;
  localparam int CNT_W    = 10;
  localparam int HALF_W   = 9;
  localparam int IDX_W    = 8;

  // Result queue depth
  localparam int QDEPTH   = 3;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_CELL_SIZE      = 8'd0;
  localparam logic [IDX_W-1:0] REG_CELLS_ACROSS   = 8'd1;
  localparam logic [IDX_W-1:0] REG_CELLS_DOWN     = 8'd2;
  localparam logic [IDX_W-1:0] REG_DARK_THRESHOLD = 8'd3;

  // Register reset values
  localparam logic [SIZE_W-1:0] RST_CELL_SIZE      = 5'd7;
  localparam logic [7:0]        RST_CELLS_ACROSS   = 8'd128;
  localparam logic [7:0]        RST_CELLS_DOWN     = 8'd64;
  localparam logic [7:0]        RST_DARK_THRESHOLD = 8'd35;

  typedef struct packed {
    logic [SIZE_W-1:0] cell_size;
    logic [7:0]        cells_across;
    logic [7:0]        cells_down;
    logic [7:0]        dark_threshold;
  } cfg_t;

  // Per-pixel control handed from the position tracker to the counter
  typedef struct packed {
    logic              dark;
    logic [COL_W-1:0]  col;
    logic              first;
    logic              emit;
    logic [HALF_W-1:0] half;
    logic [ROW_W-1:0]  row;
    logic              last;
  } ctl_t;

  typedef struct packed {
    logic              cell_on;
    logic [OUT_CW-1:0] cell_column;
    logic [ROW_W-1:0]  cell_row;
    logic              last_cell;
  } res_t;

endpackage

@@ sv/dpbmb_pixel_if.sv @@
// ----------------------------------------------------------------------------
// dpbmb_pixel_if - pixel channel
// Valid/ready channel carrying one pixel per beat.
// ----------------------------------------------------------------------------
interface dpbmb_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic       inside_image;

  modport source (output valid, red, green, inside_image, input ready);
  modport sink   (input valid, red, green, inside_image, output ready);
endinterface

@@ sv/dpbmb_cell_if.sv @@
// ----------------------------------------------------------------------------
// dpbmb_cell_if - cell result channel
// Valid/ready channel carrying one finished cell per beat.
// ----------------------------------------------------------------------------
interface dpbmb_cell_if;
  logic       valid;
  logic       ready;
  logic       cell_on;
  logic [6:0] cell_column;
  logic [6:0] cell_row;
  logic       last_cell;

  modport source (output valid, cell_on, cell_column, cell_row, last_cell, input ready);
  modport sink   (input valid, cell_on, cell_column, cell_row, last_cell, output ready);
endinterface

@@ sv/dpbmb_cfg_if.sv @@
// ----------------------------------------------------------------------------
// dpbmb_cfg_if - register write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
interface dpbmb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/dpbmb_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dpbmb_cfg_regs - configuration register file
// Takes one register write per beat; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module dpbmb_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  dpbmb_cfg_if.sink           regs,
  output dpbmb_pkg::cfg_t     cfg
);

  assign regs.ready = 1'b1;

  // Decode and hold register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_size      <= dpbmb_pkg::RST_CELL_SIZE;
      cfg.cells_across   <= dpbmb_pkg::RST_CELLS_ACROSS;
      cfg.cells_down     <= dpbmb_pkg::RST_CELLS_DOWN;
      cfg.dark_threshold <= dpbmb_pkg::RST_DARK_THRESHOLD;
    end else if (regs.valid) begin
      case (regs.index)
        dpbmb_pkg::REG_CELL_SIZE:      cfg.cell_size      <= regs.data[dpbmb_pkg::SIZE_W-1:0];
        dpbmb_pkg::REG_CELLS_ACROSS:   cfg.cells_across   <= regs.data;
        dpbmb_pkg::REG_CELLS_DOWN:     cfg.cells_down     <= regs.data;
        dpbmb_pkg::REG_DARK_THRESHOLD: cfg.dark_threshold <= regs.data;
        default: ;
      endcase
    end
  end

endmodule

@@ sv/dpbmb_position.sv @@
// ----------------------------------------------------------------------------
// dpbmb_position - raster position tracker and dark test
// Derives per-pixel control from the current position and steps the
// position forward on each accepted pixel.
// ----------------------------------------------------------------------------
module dpbmb_position (
  input  logic                           clk,
  input  logic                           rst,
  input  dpbmb_pkg::cfg_t                cfg,
  input  logic                           accept,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic                           inside_image,
  output dpbmb_pkg::ctl_t                ctl
);

  localparam int SIZE_W = dpbmb_pkg::SIZE_W;
  localparam int COL_W  = dpbmb_pkg::COL_W;
  localparam int ACR_W  = dpbmb_pkg::ACR_W;
  localparam int ROW_W  = dpbmb_pkg::ROW_W;

  logic [SIZE_W-1:0] column_in_cell;
  logic [SIZE_W-1:0] pixel_row_in_cell;
  logic [COL_W-1:0]  cell_column;
  logic [ROW_W-1:0]  cell_row;

  logic [SIZE_W-1:0] cs;
  logic [ACR_W-1:0]  ca;
  logic [7:0]        cd;
  logic [8:0]        sum;
  logic [9:0]        area;
  logic              col_end;
  logic              row_end;
  logic              across_end;
  logic              down_end;

  // Clamp the settings into their working ranges
  always_comb begin
    if (cfg.cell_size == '0) begin
      cs = SIZE_W'(1);
    end else if ({2'b00, cfg.cell_size} > 7'(dpbmb_pkg::MAX_CELL_SIZE)) begin
      cs = SIZE_W'(dpbmb_pkg::MAX_CELL_SIZE);
    end else begin
      cs = cfg.cell_size;
    end

    if (cfg.cells_across == '0) begin
      ca = ACR_W'(1);
    end else if (ACR_W'(cfg.cells_across) > ACR_W'(dpbmb_pkg::MAX_CELLS_ACROSS)) begin
      ca = ACR_W'(dpbmb_pkg::MAX_CELLS_ACROSS);
    end else begin
      ca = ACR_W'(cfg.cells_across);
    end

    if (cfg.cells_down == '0) begin
      cd = 8'd1;
    end else if (cfg.cells_down > 8'(dpbmb_pkg::MAX_CELLS_DOWN)) begin
      cd = 8'(dpbmb_pkg::MAX_CELLS_DOWN);
    end else begin
      cd = cfg.cells_down;
    end
  end

  // Position flags and per-pixel control
  assign col_end    = ({1'b0, column_in_cell} + 6'd1) >= {1'b0, cs};
  assign row_end    = ({1'b0, pixel_row_in_cell} + 6'd1) >= {1'b0, cs};
  assign across_end = (ACR_W'(cell_column) + ACR_W'(1)) >= ca;
  assign down_end   = ({1'b0, cell_row} + 8'd1) >= cd;

  assign sum  = {1'b0, red} + {1'b0, green};
  assign area = 10'(cs) * 10'(cs);

  assign ctl.dark  = inside_image && (sum[8:1] < cfg.dark_threshold);
  assign ctl.col   = cell_column;
  assign ctl.first = (pixel_row_in_cell == '0) && (column_in_cell == '0);
  assign ctl.emit  = col_end && row_end;
  assign ctl.half  = area[9:1];
  assign ctl.row   = cell_row;
  assign ctl.last  = across_end && down_end;

  // Advance the raster position on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      column_in_cell    <= '0;
      pixel_row_in_cell <= '0;
      cell_column       <= '0;
      cell_row          <= '0;
    end else if (accept) begin
      if (!col_end) begin
        column_in_cell <= column_in_cell + SIZE_W'(1);
      end else begin
        column_in_cell <= '0;
        if (!across_end) begin
          cell_column <= cell_column + COL_W'(1);
        end else begin
          cell_column <= '0;
          if (!row_end) begin
            pixel_row_in_cell <= pixel_row_in_cell + SIZE_W'(1);
          end else begin
            pixel_row_in_cell <= '0;
            if (!down_end) begin
              cell_row <= cell_row + ROW_W'(1);
            end else begin
              cell_row <= '0;
            end
          end
        end
      end
    end
  end

endmodule

@@ sv/dpbmb_counter.sv @@
// ----------------------------------------------------------------------------
// dpbmb_counter - per-column dark count store and cell decision
// Registers the pixel control with the stored count, adds the dark bit,
// writes the count back and forms the cell result on a cell's last pixel.
// ----------------------------------------------------------------------------
module dpbmb_counter (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  dpbmb_pkg::ctl_t     ctl,
  output logic                push,
  output dpbmb_pkg::res_t     res
);

  localparam int COL_W = dpbmb_pkg::COL_W;
  localparam int CNT_W = dpbmb_pkg::CNT_W;
  localparam int DEPTH = dpbmb_pkg::MAX_CELLS_ACROSS;

  logic [CNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written;

  dpbmb_pkg::ctl_t  s1;
  logic             s1_valid;
  logic [CNT_W-1:0] rdata;
  logic             rwritten;
  logic             fwd_hit;
  logic [CNT_W-1:0] fwd_data;
  logic [CNT_W-1:0] prev;
  logic [CNT_W-1:0] count;

  // Pick the stored count; a write at the read edge wins over the array
  always_comb begin
    if (fwd_hit) begin
      prev = fwd_data;
    end else if (rwritten) begin
      prev = rdata;
    end else begin
      prev = '0;
    end
    if (s1.first) begin
      count = CNT_W'(s1.dark);
    end else begin
      count = prev + CNT_W'(s1.dark);
    end
  end

  // Capture the pixel and read its column count
  always_ff @(posedge clk) begin
    if (accept) begin
      s1       <= ctl;
      rdata    <= mem[ctl.col];
      rwritten <= written[ctl.col];
      fwd_hit  <= s1_valid && (s1.col == ctl.col);
      fwd_data <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  // Write the updated count back
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      mem[s1.col] <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (s1_valid) begin
      written[s1.col] <= 1'b1;
    end
  end

  // Form the cell result
  assign push            = s1_valid && s1.emit;
  assign res.cell_on     = count > CNT_W'(s1.half);
  assign res.cell_column = dpbmb_pkg::OUT_CW'(s1.col);
  assign res.cell_row    = s1.row;
  assign res.last_cell   = s1.last;

endmodule

@@ sv/dpbmb_result_queue.sv @@
// ----------------------------------------------------------------------------
// dpbmb_result_queue - small result queue in front of the output channel
// Holds finished cells and reports whether one more pixel may enter.
// ----------------------------------------------------------------------------
module dpbmb_result_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dpbmb_pkg::res_t     res,
  output logic                space,
  dpbmb_cell_if.source        results
);

  localparam int QDEPTH = dpbmb_pkg::QDEPTH;
  localparam int QPTR_W = dpbmb_pkg::QPTR_W;
  localparam int QCNT_W = dpbmb_pkg::QCNT_W;

  dpbmb_pkg::res_t     entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                pop;
  dpbmb_pkg::res_t     head;

  assign pop  = results.valid && results.ready;
  assign head = entries[rd_ptr];

  // Room for one more result counting the one still in the count stage
  assign space = ({1'b0, count} + {QCNT_W'(0), push}) < (QCNT_W + 1)'(QDEPTH);

  assign results.valid       = count != '0;
  assign results.cell_on     = head.cell_on;
  assign results.cell_column = head.cell_column;
  assign results.cell_row    = head.cell_row;
  assign results.last_cell   = head.last_cell;

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= res;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/dark_pixel_block_majority_binner_top.sv @@
// ----------------------------------------------------------------------------
// dark_pixel_block_majority_binner_top - block majority binarizer
// Counts dark pixels per cell over a raster region and emits one bit per cell.
// ----------------------------------------------------------------------------
//  channel   dir   beat
//  pixels    in    red, green, inside_image
//  results   out   cell_on, cell_column, cell_row, last_cell
//  regs      in    index, data (register write)
//
//  One pixel per cycle while the queue has room. The count stage registers
//  the pixel with its column count read; the read-modify-write result is pushed.
//  Reset is synchronous; the count store needs no clearing pass, a valid bit
//  per column reads unwritten columns as zero.
//  A stalled results channel fills a three-entry queue, then pixels stops.
// ----------------------------------------------------------------------------
module dark_pixel_block_majority_binner_top (
  input  logic           clk,
  input  logic           rst,
  dpbmb_pixel_if.sink    pixels,
  dpbmb_cell_if.source   results,
  dpbmb_cfg_if.sink      regs
);

  dpbmb_pkg::cfg_t cfg;
  dpbmb_pkg::ctl_t pix_ctl;
  dpbmb_pkg::res_t res;
  logic            pix_accept;
  logic            push;
  logic            space;

  assign pixels.ready = space;
  assign pix_accept   = pixels.valid && pixels.ready;

  dpbmb_cfg_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .regs (regs),
    .cfg  (cfg)
  );

  dpbmb_position u_position (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (pix_accept),
    .red          (pixels.red),
    .green        (pixels.green),
    .inside_image (pixels.inside_image),
    .ctl          (pix_ctl)
  );

  dpbmb_counter u_counter (
    .clk    (clk),
    .rst    (rst),
    .accept (pix_accept),
    .ctl    (pix_ctl),
    .push   (push),
    .res    (res)
  );

  dpbmb_result_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .res     (res),
    .space   (space),
    .results (results)
  );

  // A cell's last pixel turns into a queue push on the next cycle
  a_emit_push: assert property (@(posedge clk) disable iff (rst)
    pix_accept && pix_ctl.emit |=> push)
    else $error("cell end pixel did not push a result");

  // Backpressure on pixels only while results are waiting
  a_stall_has_results: assert property (@(posedge clk) disable iff (rst)
    !pixels.ready |-> results.valid)
    else $error("pixels stalled with an empty result queue");

  // The queue only empties by a beat on the results channel
  a_drain_by_beat: assert property (@(posedge clk) disable iff (rst)
    $fell(results.valid) |-> $past(results.ready))
    else $error("result dropped without a beat");

endmodule
